/* hdl/fpct_pkg.sv */
// Package for the flow packet counter table: sizes, payload structs and
// the command/status structs between controller and datapath. No dependencies.
package fpct_pkg;

  localparam int BUCKETS  = 256;
  localparam int FLOWS    = 1024;
  localparam int KEY_BITS = 104;
  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int PTR_W    = $clog2(FLOWS) + 1;   // one more bit for the null pointer
  localparam int IDX_W    = $clog2(FLOWS);
  localparam int CNT_W    = 32;
  localparam int TOT_W    = 11;
  localparam int HB_W     = 9;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(FLOWS);

  // Register indexes on the configuration port.
  localparam logic ADDR_BUCKETS   = 1'b0;
  localparam logic ADDR_THRESHOLD = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] key_low;
    logic [39:0] key_high;
  } req_t;

  typedef struct packed {
    logic             flow_found;
    logic [CNT_W-1:0] flow_packets;
    logic [TOT_W-1:0] flow_total;
    logic [TOT_W-1:0] large_flow_total;
    logic [CNT_W-1:0] large_flow_packets;
    logic             table_full;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // capture request and hash
    logic take_head;   // pointer := head read data
    logic take_link;   // pointer := link read data
    logic do_hit;      // apply hit
    logic do_miss;     // apply miss
    logic clr_step;    // write one head entry to empty during the clearing pass
    logic clr_start;   // restart the clearing pass
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_valid;   // pointer below nodes_used
    logic key_match;   // node key equals request key
    logic clr_last;    // clearing pass on its last entry
  } sts_t;

  // 16-bit XOR fold of the key, big-endian words, zero byte padded.
  function automatic logic [15:0] key_fold(input logic [KEY_BITS-1:0] k);
    localparam int NB = (KEY_BITS + 7) / 8;
    localparam int NW = (NB + 1) / 2;
    logic [NW*16-1:0] padded;
    logic [15:0]      h;
    padded = '0;
    padded[NW*16-1 -: NB*8] = (NB*8)'(k);
    h = '0;
    for (int i = 0; i < NW; i++) h ^= padded[i*16 +: 16];
    return h;
  endfunction

endpackage

/* hdl/fpct_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module fpct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read the addressed word into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/fpct_modulo.sv */
// Iterative restoring remainder of the 16-bit hash by the bucket count.
// Depends on fpct_pkg.
module fpct_modulo import fpct_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [15:0]      dividend,
  input  logic [HB_W-1:0]  divisor,
  output logic             done,
  output logic [BKT_W-1:0] remainder
);

  logic [15:0]     quo;
  logic [HB_W:0]   rem;
  logic [4:0]      step;
  logic            busy;
  logic [HB_W:0]   trial;

  assign trial     = {rem[HB_W-1:0], quo[15]};
  assign remainder = rem[BKT_W-1:0];

  // One quotient bit per cycle, over all sixteen bits of the dividend.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        quo <= {quo[14:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
        end else begin
          rem <= trial;
        end
        step <= step + 5'd1;
        if (step == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/fpct_datapath.sv */
// Datapath: head, key, count and link memories, request registers and totals.
// Depends on fpct_pkg, fpct_ram and fpct_modulo.
module fpct_datapath import fpct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              hash_done,
  input  req_t              req,
  input  logic [HB_W-1:0]   hash_buckets,
  input  logic [CNT_W-1:0]  large_threshold,
  input  logic              clear_totals,
  output rsp_t              rsp
);

  logic             lookup;
  logic [KEY_BITS-1:0] key;
  logic [BKT_W-1:0] bucket;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] nodes_used;
  logic [TOT_W-1:0] large_count;
  logic [CNT_W-1:0] large_sum;
  logic [BKT_W-1:0] clr_idx;
  logic [HB_W-1:0]  n_eff;
  logic [BKT_W-1:0] rem;

  logic [PTR_W-1:0]    head_rd, link_rd;
  logic [KEY_BITS-1:0] key_rd;
  logic [CNT_W-1:0]    cnt_rd;
  logic                head_we, node_we;
  logic [BKT_W-1:0]    head_addr;
  logic [PTR_W-1:0]    head_wd;
  logic [IDX_W-1:0]    node_addr;
  logic                cnt_we;
  logic [CNT_W-1:0]    cnt_wd;
  logic                full;
  logic [CNT_W-1:0]    cnt_new;
  logic [CNT_W:0]      sum_wide;
  logic [CNT_W-1:0]    sum_add;
  logic                becomes_large;
  logic                res_found;
  logic [CNT_W-1:0]    res_packets;
  logic                res_full;

  // Effective bucket count: zero reads as one, above BUCKETS as BUCKETS.
  always_comb begin
    n_eff = hash_buckets;
    if (hash_buckets == '0) n_eff = HB_W'(1);
    if (hash_buckets > HB_W'(BUCKETS)) n_eff = HB_W'(BUCKETS);
  end

  fpct_modulo u_mod (
    .clk(clk), .rst(rst), .start(cmd.load_req),
    .dividend(key_fold({req.key_high, req.key_low})),
    .divisor(n_eff), .done(hash_done), .remainder(rem)
  );

  // Request, pointer and bucket registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      lookup <= req.req_type;
      key    <= {req.key_high, req.key_low};
    end
    if (hash_done) bucket <= rem;
    if (cmd.take_head) ptr <= head_rd;
    if (cmd.take_link) ptr <= link_rd;
  end

  assign full    = (nodes_used >= PTR_W'(FLOWS));
  assign cnt_new = (cnt_rd == '1) ? cnt_rd : cnt_rd + CNT_W'(1);

  // Memory controls: clearing pass, head update on insert, count update on hit.
  always_comb begin
    head_we   = cmd.clr_step || (cmd.do_miss && !lookup && !full);
    head_addr = cmd.clr_step ? clr_idx : bucket;
    head_wd   = cmd.clr_step ? NIL : nodes_used;
    node_we   = cmd.do_miss && !lookup && !full;
    node_addr = node_we ? nodes_used[IDX_W-1:0] : ptr[IDX_W-1:0];
    cnt_we    = node_we || (cmd.do_hit && !lookup);
    cnt_wd    = node_we ? CNT_W'(1) : cnt_new;
  end

  fpct_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .we(head_we), .addr(head_addr), .wdata(head_wd), .rdata(head_rd));
  fpct_ram #(.WIDTH(KEY_BITS), .DEPTH(FLOWS)) u_keys (
    .clk(clk), .we(node_we), .addr(node_addr), .wdata(key), .rdata(key_rd));
  fpct_ram #(.WIDTH(CNT_W), .DEPTH(FLOWS)) u_counts (
    .clk(clk), .we(cnt_we), .addr(node_addr), .wdata(cnt_wd), .rdata(cnt_rd));
  fpct_ram #(.WIDTH(PTR_W), .DEPTH(FLOWS)) u_links (
    .clk(clk), .we(node_we), .addr(node_addr), .wdata(head_rd), .rdata(link_rd));

  assign sts.ptr_valid = (ptr < nodes_used);
  assign sts.key_match = (key_rd == key);
  assign sts.clr_last  = (clr_idx == BKT_W'(BUCKETS - 1));

  // Increment to the large-packet sum for the newly counted packet.
  always_comb begin
    becomes_large = 1'b0;
    sum_add       = '0;
    if (cmd.do_hit) begin
      if (cnt_new >= large_threshold) begin
        becomes_large = (cnt_rd < large_threshold);
        sum_add       = becomes_large ? cnt_new : cnt_new - cnt_rd;
      end
    end else if (CNT_W'(1) >= large_threshold) begin
      becomes_large = 1'b1;
      sum_add       = CNT_W'(1);
    end
    sum_wide = {1'b0, large_sum} + {1'b0, sum_add};
  end

  // Totals, clearing index and result register.
  always_ff @(posedge clk) begin
    if (rst || clear_totals) begin
      nodes_used  <= '0;
      large_count <= '0;
      large_sum   <= '0;
      clr_idx     <= '0;
    end else begin
      if (cmd.clr_start) clr_idx <= '0;
      else if (cmd.clr_step) clr_idx <= clr_idx + BKT_W'(1);
      if ((cmd.do_hit && !lookup) || node_we) begin
        if (node_we) nodes_used <= nodes_used + PTR_W'(1);
        if (becomes_large) large_count <= large_count + TOT_W'(1);
        large_sum <= sum_wide[CNT_W] ? '1 : sum_wide[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_hit) begin
      res_found   <= 1'b1;
      res_packets <= lookup ? cnt_rd : cnt_new;
      res_full    <= 1'b0;
    end else if (cmd.do_miss) begin
      res_found   <= 1'b0;
      res_packets <= (lookup || full) ? '0 : CNT_W'(1);
      res_full    <= !lookup && full;
    end
  end

  assign rsp.flow_found         = res_found;
  assign rsp.flow_packets       = res_packets;
  assign rsp.table_full         = res_full;
  assign rsp.flow_total         = TOT_W'(nodes_used);
  assign rsp.large_flow_total   = large_count;
  assign rsp.large_flow_packets = large_sum;

endmodule

/* hdl/fpct_ctrl.sv */
// Controller state machine: clearing pass, hash wait, chain walk, result handshake.
// Depends on fpct_pkg.
module fpct_ctrl import fpct_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic clear_req,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic hash_done,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_TAKE  = 3'd4;
  localparam logic [2:0] S_NODE  = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_HASH;
        end
      end
      S_HASH: if (hash_done) state_next = S_HEAD;
      S_HEAD: begin
        state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.take_head = 1'b1;
        state_next    = S_NODE;
      end
      S_NODE: begin
        if (sts.ptr_valid) begin
          state_next = S_CMP;
        end else begin
          cmd.do_miss = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_CMP: begin
        if (sts.key_match) begin
          cmd.do_hit = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.take_link = 1'b1;
          state_next    = S_NODE;
        end
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (clear_req) begin
      cmd.clr_start = 1'b1;
      state_next    = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/flow_packet_counter_table_core.sv */
// Top level of the flow packet counter table: configuration registers and
// the controller/datapath pair. Depends on fpct_pkg, fpct_ctrl, fpct_datapath.
//
// Usage: a request transaction (req_valid/req_ready, payload req) carries a
// flow key and a type: count one packet, or look up only. Exactly one result
// transaction (rsp_valid/rsp_ready, payload rsp) follows for each request.
// The key hash is reduced by a bit-serial remainder unit, the bucket is
// registered, the bucket head is read, then the chain is walked node by
// node, as each node read passes through the registered read of the node
// memories, until the key is found or the chain ends. One request is in
// flight at a time, and the next is taken only after the result has been
// taken and the controller is back in its idle state.
// The result is held in a register until taken; a stalled receiver holds
// the block, and no new request is taken meanwhile.
// After reset, and after any configuration write, the bucket head memory is
// swept to empty entry by entry while no request is taken; totals clear
// at once. Registers sit on an APB-style port, index 0 at address 0 and
// index 1 at address 4.
module flow_packet_counter_table_core import fpct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [HB_W-1:0]  hash_buckets;
  logic [CNT_W-1:0] large_threshold;
  logic             wr;
  logic             clear_req;
  logic             hash_done;
  cmd_t             cmd;
  sts_t             sts;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign clear_req = wr;

  // Configuration registers; any write empties the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_buckets    <= HB_W'(256);
      large_threshold <= CNT_W'(100);
    end else if (clear_req) begin
      if (paddr[2] == ADDR_BUCKETS) hash_buckets <= pwdata[HB_W-1:0];
      else large_threshold <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ADDR_THRESHOLD) prdata = large_threshold;
    else prdata = 32'(hash_buckets);
  end

  fpct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .clear_req(clear_req),
    .in_valid(req_valid), .in_ready(req_ready),
    .out_valid(rsp_valid), .out_ready(rsp_ready),
    .hash_done(hash_done), .sts(sts), .cmd(cmd)
  );

  fpct_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .hash_done(hash_done),
    .req(req), .hash_buckets(hash_buckets), .large_threshold(large_threshold),
    .clear_totals(clear_req), .rsp(rsp)
  );

endmodule
